// ===== hdl/c8core_pkg.sv =====
// Shared types and constants for the CHIP-8 instruction core.
package c8core_pkg;

    localparam int MemBytes   = 4096;
    localparam int ScreenW    = 64;
    localparam int ScreenH    = 32;
    localparam int StackDepth = 16;

    localparam logic [11:0] START_PC = 12'h200;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_EXEC  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_ROW   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BADKEY  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_WAIT    = 3'd5;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0]  KK_SKP  = 8'h9E;
    localparam logic [7:0]  KK_SKNP = 8'hA1;
    localparam logic [7:0]  KK_LDDT = 8'h07;
    localparam logic [7:0]  KK_WKEY = 8'h0A;
    localparam logic [7:0]  KK_SDT  = 8'h15;
    localparam logic [7:0]  KK_SST  = 8'h18;
    localparam logic [7:0]  KK_ADDI = 8'h1E;
    localparam logic [7:0]  KK_FONT = 8'h29;
    localparam logic [7:0]  KK_BCD  = 8'h33;
    localparam logic [7:0]  KK_STOR = 8'h55;
    localparam logic [7:0]  KK_LOAD = 8'h65;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] addr;
        logic [7:0]  wdata;
        logic [15:0] keys;
        logic [7:0]  random_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] pc_out;
        logic [15:0] opcode_out;
        logic [63:0] row_data;
        logic        sound_on;
    } t_out_item;

    // Memory request from the sequencer to the byte memory.
    typedef struct packed {
        logic        we;
        logic [11:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

endpackage

// ===== hdl/c8core_mem.sv =====
// 4096-byte program memory with a single port: one shared address for the write and the registered read.
module c8core_mem (
    input  logic                 i_clk,
    input  c8core_pkg::t_mem_req i_req,
    output logic [7:0]           o_rdata
);
    import c8core_pkg::*;

    logic [7:0] r_mem [MemBytes];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end
endmodule

// ===== hdl/c8core_fb.sv =====
// Frame buffer: 32 rows of 64 pixels, one row read and one row written a cycle.
module c8core_fb (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic [4:0]  i_raddr,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [63:0] i_wdata,
    output logic [63:0] o_rdata
);
    import c8core_pkg::*;

    logic [63:0]      r_rows [ScreenH];
    logic [ScreenH-1:0] r_valid;
    logic [63:0]      r_rd;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
        if (i_we) begin
            r_rows[i_waddr] <= i_wdata;
        end
        r_rd       <= r_rows[i_raddr];
        r_rd_valid <= r_valid[i_raddr] && !(i_clear);
    end

    assign o_rdata = r_rd_valid ? r_rd : 64'd0;
endmodule

// ===== hdl/chip8_instruction_core.sv =====
// Top level: CHIP-8 sequencer with shared ALU, byte memory and frame buffer.
// Raise start while busy is low; busy then holds for the whole item and the
// result appears for one cycle with o_done, which the receiver cannot stall.
// A memory write or timer tick goes straight to the done state, a row read
// passes two frame-buffer read states, and an instruction passes high-byte
// fetch, low-byte fetch and decode. Draws, BCD and register block moves walk
// one memory byte or display row per step; a clear wipes the whole frame
// buffer at once. busy stays high through the strobe cycle, so the next
// transaction is taken in the cycle after it; the single-port memory sets this pacing.
module chip8_instruction_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  c8core_pkg::t_in_item  i_item,
    output logic                  o_done,
    output c8core_pkg::t_out_item o_item
);
    import c8core_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FH    = 4'd1;
    localparam logic [3:0] S_FL    = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_DRD   = 4'd4;
    localparam logic [3:0] S_DFB   = 4'd5;
    localparam logic [3:0] S_DWR   = 4'd6;
    localparam logic [3:0] S_BLK   = 4'd7;
    localparam logic [3:0] S_LDW   = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;
    localparam logic [3:0] S_ROW   = 4'd10;
    localparam logic [3:0] S_ROW2  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]  r_state;
    t_in_item    r_in;
    logic [7:0]  r_v [16];
    logic [11:0] r_stk [StackDepth];
    logic [4:0]  r_sp;
    logic [11:0] r_pc, r_i;
    logic [7:0]  r_dt, r_st;
    logic [15:0] r_prev;
    logic [15:0] r_op;
    logic [2:0]  r_status;
    logic [4:0]  r_cnt;
    logic        r_hit;
    logic [63:0] r_row;
    logic [7:0]  r_byte;

    t_mem_req    mem_req;
    logic [7:0]  mem_rdata;
    logic        fb_clear, fb_we;
    logic [4:0]  fb_raddr, fb_waddr;
    logic [63:0] fb_wdata, fb_rdata;

    logic        in_take;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [15:0] fresh;
    logic [3:0]  low_key;
    logic [63:0] mask;
    logic [5:0]  col;
    logic [3:0]  sp_top;

    logic [7:0]  alu_res;
    logic        alu_flag, alu_wflag, alu_known;
    logic [15:0] bcd_p10, bcd_p100;
    logic [7:0]  bcd_q10, bcd_hun, bcd_ten, bcd_one;

    logic [11:0] n_pc;
    logic [2:0]  n_status;
    logic [3:0]  n_state;

    assign in_take = start && !busy;

    assign x  = r_op[11:8];
    assign y  = r_op[7:4];
    assign n  = r_op[3:0];
    assign kk = r_op[7:0];
    assign vx = r_v[x];
    assign vy = r_v[y];
    assign fresh = r_in.keys & ~r_prev;
    assign sp_top = 4'(r_sp - 5'd1);

    always_comb begin
        low_key = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (fresh[k]) low_key = 4'(k);
        end
    end

    // Sprite byte to a wrapped 64-bit row mask.
    always_comb begin
        mask = '0;
        for (int j = 0; j < 8; j++) begin
            col = vx[5:0] + 6'(j);
            if (r_byte[7-j]) mask[col] = 1'b1;
        end
    end

    // Register-to-register ALU for 8xyn; flag ops also produce VF.
    always_comb begin
        alu_res   = vy;
        alu_flag  = 1'b0;
        alu_wflag = 1'b0;
        alu_known = 1'b1;
        unique case (n)
            4'h0: alu_res = vy;
            4'h1: alu_res = vx | vy;
            4'h2: alu_res = vx & vy;
            4'h3: alu_res = vx ^ vy;
            4'h4: begin
                {alu_flag, alu_res} = {1'b0, vx} + {1'b0, vy};
                alu_wflag = 1'b1;
            end
            4'h5: begin alu_flag = vx > vy; alu_res = vx - vy; alu_wflag = 1'b1; end
            4'h6: begin alu_flag = vx[0]; alu_res = vx >> 1; alu_wflag = 1'b1; end
            4'h7: begin alu_flag = vy > vx; alu_res = vy - vx; alu_wflag = 1'b1; end
            4'hE: begin alu_flag = vx[7]; alu_res = vx << 1; alu_wflag = 1'b1; end
            default: alu_known = 1'b0;
        endcase
    end

    // Divide by 10 and 100 through reciprocal multiplication, exact for 0..255.
    assign bcd_p10  = {8'd0, vx} * 16'd205;
    assign bcd_p100 = {8'd0, vx} * 16'd41;
    assign bcd_q10  = {3'd0, bcd_p10[15:11]};
    assign bcd_hun  = {4'd0, bcd_p100[15:12]};
    assign bcd_ten  = bcd_q10 - bcd_hun * 8'd10;
    assign bcd_one  = vx - bcd_q10 * 8'd10;

    c8core_mem u_mem (.i_clk(i_clk), .i_req(mem_req), .o_rdata(mem_rdata));

    c8core_fb u_fb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(fb_clear),
        .i_raddr(fb_raddr), .i_we(fb_we), .i_waddr(fb_waddr),
        .i_wdata(fb_wdata), .o_rdata(fb_rdata)
    );

    logic [11:0] blk_addr;
    assign blk_addr = r_i + 12'(r_cnt);

    always_comb begin
        mem_req = '{we: 1'b0, addr: r_pc, wdata: 8'd0};
        fb_clear = 1'b0;
        fb_we    = 1'b0;
        fb_raddr = r_in.addr[4:0];
        fb_waddr = vy[4:0] + r_cnt;
        fb_wdata = r_row ^ mask;
        unique case (r_state)
            S_IDLE: begin
                mem_req.addr = i_item.addr;
                mem_req.wdata = i_item.wdata;
                mem_req.we = in_take && i_item.func == FUNC_WRITE;
                if (i_item.func == FUNC_EXEC) mem_req.addr = r_pc;
            end
            S_FH:  mem_req.addr = r_pc + 12'd1;
            S_DRD, S_DFB: begin
                mem_req.addr = blk_addr;
                fb_raddr = vy[4:0] + r_cnt;
            end
            S_DWR: fb_we = 1'b1;
            S_BLK: begin
                mem_req.addr = blk_addr;
                if (r_op[15:12] == 4'hF && kk == KK_BCD) begin
                    mem_req.we = 1'b1;
                    mem_req.wdata = (r_cnt == 5'd0) ? bcd_hun :
                                    (r_cnt == 5'd1) ? bcd_ten : bcd_one;
                end else if (kk == KK_STOR) begin
                    mem_req.we = 1'b1;
                    mem_req.wdata = r_v[r_cnt[3:0]];
                end
            end
            S_LDW: mem_req.addr = blk_addr;
            S_CLR: fb_clear = 1'b1;
            default: ;
        endcase
    end

    logic [11:0] pc2, pc4;
    assign pc2 = r_pc + 12'd2;
    assign pc4 = r_pc + 12'd4;

    // Decode: next pc, status and state of the fetched instruction.
    always_comb begin
        n_pc     = pc2;
        n_status = ST_OK;
        n_state  = S_DONE;
        unique case (r_op[15:12])
            4'h0: begin
                if (r_op == OP_CLS) n_state = S_CLR;
                else if (r_op == OP_RET) begin
                    if (r_sp == 5'd0) begin n_status = ST_EMPTY; n_pc = r_pc; end
                    else n_pc = r_stk[sp_top];
                end
            end
            4'h1: n_pc = r_op[11:0];
            4'h2: begin
                if (r_sp >= 5'(StackDepth)) begin n_status = ST_FULL; n_pc = r_pc; end
                else n_pc = r_op[11:0];
            end
            4'h3: if (vx == kk) n_pc = pc4;
            4'h4: if (vx != kk) n_pc = pc4;
            4'h5: if (vx == vy) n_pc = pc4;
            4'h8: if (!alu_known) n_status = ST_UNKNOWN;
            4'h9: if (vx != vy) n_pc = pc4;
            4'hB: n_pc = r_op[11:0] + {4'd0, r_v[0]};
            4'hD: if (n != 4'd0) begin n_pc = r_pc; n_state = S_DRD; end
            4'hE: begin
                if (vx > 8'd15) begin n_status = ST_BADKEY; n_pc = r_pc; end
                else if (kk == KK_SKP) begin
                    if (r_in.keys[vx[3:0]]) n_pc = pc4;
                end else if (kk == KK_SKNP) begin
                    if (!r_in.keys[vx[3:0]]) n_pc = pc4;
                end else n_status = ST_UNKNOWN;
            end
            4'hF: begin
                priority case (kk)
                    KK_LDDT, KK_SDT, KK_SST, KK_ADDI, KK_FONT: ;
                    KK_WKEY: begin
                        if (fresh == 16'd0) begin n_status = ST_WAIT; n_pc = r_pc; end
                    end
                    KK_BCD, KK_STOR, KK_LOAD: n_state = S_BLK;
                    default: n_status = ST_UNKNOWN;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_done <= i_rst_n && r_state == S_DONE;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            for (int k = 0; k < StackDepth; k++) r_stk[k] <= 12'd0;
            r_sp <= '0; r_pc <= START_PC; r_i <= '0;
            r_dt <= '0; r_st <= '0; r_prev <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_take) begin
                    r_in <= i_item;
                    r_op <= '0;
                    r_status <= ST_OK;
                    r_row <= '0;
                    r_cnt <= '0;
                    r_hit <= 1'b0;
                    unique case (i_item.func)
                        FUNC_WRITE: r_state <= S_DONE;
                        FUNC_EXEC:  r_state <= S_FH;
                        FUNC_TICK: begin
                            if (r_dt != 0) r_dt <= r_dt - 8'd1;
                            if (r_st != 0) r_st <= r_st - 8'd1;
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_ROW;
                    endcase
                end
                S_ROW:  r_state <= S_ROW2;
                S_ROW2: begin r_row <= fb_rdata; r_state <= S_DONE; end
                S_FH: begin r_op[15:8] <= mem_rdata; r_state <= S_FL; end
                S_FL: begin r_op[7:0] <= mem_rdata; r_state <= S_DEC; end
                S_DEC: begin
                    r_state  <= n_state;
                    r_pc     <= n_pc;
                    r_status <= n_status;
                    unique case (r_op[15:12])
                        4'h0: if (r_op == OP_RET && r_sp != 5'd0) r_sp <= r_sp - 5'd1;
                        4'h2: begin
                            if (r_sp < 5'(StackDepth)) begin
                                r_stk[r_sp[3:0]] <= pc2;
                                r_sp <= r_sp + 5'd1;
                            end
                        end
                        4'h6: r_v[x] <= kk;
                        4'h7: r_v[x] <= vx + kk;
                        4'h8: begin
                            // With x = F the result wins over the flag.
                            if (alu_known) begin
                                if (alu_wflag && x != 4'hF) r_v[15] <= {7'd0, alu_flag};
                                r_v[x] <= alu_res;
                            end
                        end
                        4'hA: r_i <= r_op[11:0];
                        4'hC: r_v[x] <= r_in.random_byte & kk;
                        4'hD: if (n == 4'd0) r_v[15] <= 8'd0;
                        4'hF: begin
                            priority case (kk)
                                KK_LDDT: r_v[x] <= r_dt;
                                KK_WKEY: if (fresh != 16'd0) r_v[x] <= {4'd0, low_key};
                                KK_SDT: r_dt <= vx;
                                KK_SST: r_st <= vx;
                                KK_ADDI: r_i <= r_i + {4'd0, vx};
                                KK_FONT: r_i <= 12'({vx, 2'b00}) + {4'd0, vx};
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                S_DRD: r_state <= S_DFB;
                S_DFB: begin
                    r_byte <= mem_rdata;
                    r_row <= fb_rdata;
                    r_state <= S_DWR;
                end
                S_DWR: begin
                    if ((r_row & mask) != 0) r_hit <= 1'b1;
                    if (r_cnt == 5'(n) - 5'd1) begin
                        r_v[15] <= {7'd0, r_hit || ((r_row & mask) != 0)};
                        r_pc <= pc2;
                        r_row <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                        r_state <= S_DRD;
                    end
                end
                S_BLK: begin
                    if (kk == KK_LOAD) r_state <= S_LDW;
                    else if ((kk == KK_BCD && r_cnt == 5'd2) ||
                             (kk != KK_BCD && r_cnt[3:0] == x)) r_state <= S_DONE;
                    else r_cnt <= r_cnt + 5'd1;
                end
                S_LDW: begin
                    r_v[r_cnt[3:0]] <= mem_rdata;
                    if (r_cnt[3:0] == x) r_state <= S_DONE;
                    else begin r_cnt <= r_cnt + 5'd1; r_state <= S_BLK; end
                end
                S_CLR: r_state <= S_DONE;
                S_DONE: begin
                    if (r_in.func == FUNC_EXEC) r_prev <= r_in.keys;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_item.status     = r_status;
        o_item.pc_out     = r_pc;
        o_item.opcode_out = r_op;
        o_item.row_data   = r_row;
        o_item.sound_on   = r_st != 8'd0;
    end

    assign busy = r_state != S_IDLE || o_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> r_state == S_IDLE)
        else $error("done outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_sp <= 5'(StackDepth))
        else $error("stack level overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_done) else $error("missing done");
endmodule
